>>> rtl/assert_macros.svh
// Assertion macros for the RTL; included by affinity_task_partitioner.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define AST_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/atp_pkg.sv
// Types and constants of the affinity task partitioner.
// No dependencies.
package atp_pkg;

    localparam int EXEC_W   = 16;
    localparam int PERIOD_W = 16;
    localparam int MASK_W   = 32;
    localparam int TIDX_W   = 5;
    localparam int CIDX_W   = 3;
    localparam int STATUS_W = 2;
    localparam int LOAD_W   = 18;
    localparam int CC_W     = 4;
    localparam int CFG_W    = 18;
    localparam int TCNT_W   = 6;

    localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};

    localparam logic [STATUS_W-1:0] STAT_AFFINITY = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_LEAST    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_REJECT   = 2'd2;

    localparam logic CFG_CORE_COUNT = 1'b0;
    localparam logic CFG_MAX_UTIL   = 1'b1;

    localparam logic [CC_W-1:0]   CORE_COUNT_RST = 4'd8;
    localparam logic [LOAD_W-1:0] MAX_UTIL_RST   = 18'd65536;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_COMMIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              done;
        logic [LOAD_W-1:0] quot;
    } t_div_res;

endpackage

>>> rtl/atp_task_if.sv
// Task input channel: valid/ready handshake with the task payload.
// Depends on atp_pkg.
interface atp_task_if import atp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [EXEC_W-1:0]   exec_time;
    logic [PERIOD_W-1:0] task_period;
    logic [MASK_W-1:0]   partner_mask;

    modport source (output valid, exec_time, task_period, partner_mask, input ready);
    modport sink   (input valid, exec_time, task_period, partner_mask, output ready);
endinterface

>>> rtl/atp_result_if.sv
// Result output channel: valid/ready handshake with the placement result.
// Depends on atp_pkg.
interface atp_result_if import atp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [TIDX_W-1:0]   task_index;
    logic [CIDX_W-1:0]   core_index;
    logic [STATUS_W-1:0] status;
    logic                over_limit;
    logic [LOAD_W-1:0]   core_load;

    modport source (output valid, task_index, core_index, status, over_limit, core_load,
                    input ready);
    modport sink   (input valid, task_index, core_index, status, over_limit, core_load,
                    output ready);
endinterface

>>> rtl/atp_divider.sv
// Restoring divider, one quotient bit per cycle: (exec << FRAC_BITS) / period,
// saturated to the load width. Depends on atp_pkg.
module atp_divider import atp_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [EXEC_W-1:0]   i_exec,
    input  logic [PERIOD_W-1:0] i_period,
    output t_div_res            o_res
);
    localparam int DW  = EXEC_W + FRAC_BITS;
    localparam int CNW = $clog2(DW + 1);

    logic [DW-1:0]       r_dvd, n_dvd;
    logic [DW-1:0]       r_quot, n_quot;
    logic [PERIOD_W-1:0] r_rem, n_rem;
    logic [PERIOD_W-1:0] r_per, n_per;
    logic [CNW-1:0]      r_cnt, n_cnt;
    logic                r_busy, n_busy;
    logic                r_done, n_done;

    logic [PERIOD_W:0]   w_trial;
    logic                w_ge;

    always_comb begin
        w_trial = {r_rem, r_dvd[DW-1]};
        w_ge    = w_trial >= {1'b0, r_per};
        n_dvd   = r_dvd;
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_per   = r_per;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_dvd  = {i_exec, {FRAC_BITS{1'b0}}};
            n_quot = '0;
            n_rem  = '0;
            n_per  = i_period;
            n_cnt  = CNW'(DW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_dvd  = {r_dvd[DW-2:0], 1'b0};
            n_quot = {r_quot[DW-2:0], w_ge};
            n_rem  = w_ge ? PERIOD_W'(w_trial - {1'b0, r_per}) : w_trial[PERIOD_W-1:0];
            n_cnt  = r_cnt - CNW'(1);
            if (r_cnt == CNW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd  <= n_dvd;
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_per  <= n_per;
    end

    assign o_res.done = r_done;
    assign o_res.quot = (|r_quot[DW-1:LOAD_W]) ? LOAD_MAX : r_quot[LOAD_W-1:0];

endmodule

>>> rtl/affinity_task_partitioner.sv
// An accepted task passes through S_DIV (divide), S_SCAN (cores visited from 0 until an
// affinity hit or the last core in use), S_COMMIT and S_OUT (output load). A rejected task
// goes from S_IDLE straight to S_OUT. One item at a time: the next item is taken in S_IDLE,
// after the result loads, also while that result still waits on the output register.
// Synchronous active-low reset clears core loads, memberships, task count and output valid,
// and sets core count and max utilisation to their defaults.
`include "assert_macros.svh"

module affinity_task_partitioner import atp_pkg::*; #(
    parameter int CORE_SLOTS = 8,
    parameter int TASK_SLOTS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [CFG_W-1:0]    i_cfg_data,
    atp_task_if.sink            i_task,
    atp_result_if.source        o_result
);
    localparam int CIW = (CORE_SLOTS > 1) ? $clog2(CORE_SLOTS) : 1;
    localparam int MIW = $clog2(MASK_W);

    t_state r_state, n_state;

    logic [CC_W-1:0]     r_cc;
    logic [LOAD_W-1:0]   r_max_util;
    logic [LOAD_W-1:0]   r_load [CORE_SLOTS];
    logic [MASK_W-1:0]   r_members [CORE_SLOTS];
    logic [TCNT_W-1:0]   r_tasks;

    logic [MASK_W-1:0]   r_mask, n_mask;
    logic                r_reject, n_reject;
    logic [LOAD_W-1:0]   r_u, n_u;
    logic [CIW-1:0]      r_scan, n_scan;
    logic                r_found, n_found;
    logic [CIW-1:0]      r_chosen, n_chosen;
    logic [LOAD_W-1:0]   r_sel_load, n_sel_load;
    logic [CIW-1:0]      r_min_idx, n_min_idx;
    logic [LOAD_W-1:0]   r_min_load, n_min_load;
    logic [LOAD_W-1:0]   r_new_load, n_new_load;
    logic                r_over, n_over;

    logic                r_out_valid, n_out_valid;
    logic [TIDX_W-1:0]   r_out_tidx, n_out_tidx;
    logic [CIDX_W-1:0]   r_out_cidx, n_out_cidx;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic                r_out_over, n_out_over;
    logic [LOAD_W-1:0]   r_out_load, n_out_load;

    logic                w_accept;
    logic                w_reject;
    logic                w_div_start;
    t_div_res            w_div;
    logic [CIW-1:0]      w_last;
    logic [LOAD_W-1:0]   w_cur;
    logic [LOAD_W:0]     w_fit_sum;
    logic                w_hit;
    logic                w_min_upd;
    logic [LOAD_W:0]     w_commit_sum;
    logic [LOAD_W-1:0]   w_commit_load;
    logic                w_out_free;

    atp_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start),
        .i_exec   (i_task.exec_time),
        .i_period (i_task.task_period),
        .o_res    (w_div)
    );

    assign i_task.ready = (r_state == S_IDLE);
    assign w_accept     = i_task.valid && i_task.ready;
    assign w_reject     = (i_task.task_period == '0)
                       || ({1'b0, r_tasks} >= (TCNT_W+1)'(TASK_SLOTS));
    assign w_div_start  = w_accept && !w_reject;
    assign w_out_free   = !r_out_valid || o_result.ready;

    always_comb begin
        if (r_cc == '0) begin
            w_last = '0;
        end else if ({1'b0, r_cc} > (CC_W+1)'(CORE_SLOTS)) begin
            w_last = CIW'(CORE_SLOTS - 1);
        end else begin
            w_last = CIW'(r_cc - CC_W'(1));
        end
    end

    assign w_cur         = r_load[r_scan];
    assign w_fit_sum     = {1'b0, w_cur} + {1'b0, r_u};
    assign w_hit         = (w_fit_sum <= {1'b0, r_max_util}) && (|(r_members[r_scan] & r_mask));
    assign w_min_upd     = (r_scan == '0) || (w_cur < r_min_load);
    assign w_commit_sum  = {1'b0, r_sel_load} + {1'b0, r_u};
    assign w_commit_load = w_commit_sum[LOAD_W] ? LOAD_MAX : w_commit_sum[LOAD_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_reject ? S_OUT : S_DIV;
                end
            end
            S_DIV: begin
                if (w_div.done) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_hit || (r_scan == w_last)) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: n_state = S_OUT;
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_mask       = r_mask;
        n_reject     = r_reject;
        n_u          = r_u;
        n_scan       = r_scan;
        n_found      = r_found;
        n_chosen     = r_chosen;
        n_sel_load   = r_sel_load;
        n_min_idx    = r_min_idx;
        n_min_load   = r_min_load;
        n_new_load   = r_new_load;
        n_over       = r_over;
        n_out_valid  = r_out_valid && !o_result.ready;
        n_out_tidx   = r_out_tidx;
        n_out_cidx   = r_out_cidx;
        n_out_status = r_out_status;
        n_out_over   = r_out_over;
        n_out_load   = r_out_load;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_mask   = i_task.partner_mask;
                    n_reject = w_reject;
                    n_scan   = '0;
                    n_found  = 1'b0;
                end
            end
            S_DIV: begin
                if (w_div.done) begin
                    n_u = w_div.quot;
                end
            end
            S_SCAN: begin
                if (w_min_upd) begin
                    n_min_idx  = r_scan;
                    n_min_load = w_cur;
                end
                if (w_hit) begin
                    n_found    = 1'b1;
                    n_chosen   = r_scan;
                    n_sel_load = w_cur;
                end else if (r_scan == w_last) begin
                    n_chosen   = w_min_upd ? r_scan : r_min_idx;
                    n_sel_load = w_min_upd ? w_cur : r_min_load;
                end else begin
                    n_scan = r_scan + CIW'(1);
                end
            end
            S_COMMIT: begin
                n_new_load = w_commit_load;
                n_over     = w_commit_load > r_max_util;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_tidx  = TIDX_W'(r_tasks - (r_reject ? TCNT_W'(0) : TCNT_W'(1)));
                    if (r_reject) begin
                        n_out_cidx   = '0;
                        n_out_status = STAT_REJECT;
                        n_out_over   = 1'b0;
                        n_out_load   = '0;
                    end else begin
                        n_out_cidx   = CIDX_W'(r_chosen);
                        n_out_status = r_found ? STAT_AFFINITY : STAT_LEAST;
                        n_out_over   = r_over;
                        n_out_load   = r_new_load;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cc        <= CORE_COUNT_RST;
            r_max_util  <= MAX_UTIL_RST;
            r_tasks     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CORE_SLOTS; i++) begin
                r_load[i]    <= '0;
                r_members[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CORE_COUNT: r_cc       <= i_cfg_data[CC_W-1:0];
                    CFG_MAX_UTIL:   r_max_util <= i_cfg_data[LOAD_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == S_COMMIT) begin
                r_load[r_chosen] <= w_commit_load;
                if (r_tasks < TCNT_W'(MASK_W)) begin
                    r_members[r_chosen][r_tasks[MIW-1:0]] <= 1'b1;
                end
                r_tasks <= r_tasks + TCNT_W'(1);
            end
        end
        r_mask       <= n_mask;
        r_reject     <= n_reject;
        r_u          <= n_u;
        r_scan       <= n_scan;
        r_found      <= n_found;
        r_chosen     <= n_chosen;
        r_sel_load   <= n_sel_load;
        r_min_idx    <= n_min_idx;
        r_min_load   <= n_min_load;
        r_new_load   <= n_new_load;
        r_over       <= n_over;
        r_out_tidx   <= n_out_tidx;
        r_out_cidx   <= n_out_cidx;
        r_out_status <= n_out_status;
        r_out_over   <= n_out_over;
        r_out_load   <= n_out_load;
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.task_index = r_out_tidx;
    assign o_result.core_index = r_out_cidx;
    assign o_result.status     = r_out_status;
    assign o_result.over_limit = r_out_over;
    assign o_result.core_load  = r_out_load;

    `AST_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, !i_task.ready)
    `AST_SAME(a_over_matches_load, i_clk, i_rst_n, r_out_valid,
              r_out_over == (r_out_load > r_max_util))
    `AST_SAME(a_reject_empty, i_clk, i_rst_n, r_out_valid && (r_out_status == STAT_REJECT),
              (r_out_load == '0) && (r_out_cidx == '0))
    `AST_SAME(a_task_count_bound, i_clk, i_rst_n, 1'b1,
              int'(r_tasks) <= TASK_SLOTS)

endmodule
